// File: sv/assert_macros.svh
// Assertion macros shared by the cache RTL.
// Uses the clk and arst_n names of the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset
`define LKVC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// Condition in one cycle implies a property in the next
`define LKVC_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

// File: sv/lkvc_pkg.sv
// Package for the LRU key-value cache: beat payload types and fixed codes.
// No dependencies.
package lkvc_pkg;

	// operation codes carried in the mode field
	localparam logic MODE_GET = 1'b0;
	localparam logic MODE_PUT = 1'b1;

	// value returned on a get miss and on every put
	localparam logic signed [31:0] READ_MISS = -32'sd1;

	// capacity register
	localparam int          CAP_W     = 5;
	localparam logic [4:0]  CAP_RESET = 5'd16;

	typedef struct packed {
		logic               mode;
		logic signed [31:0] key;
		logic signed [31:0] write_value;
	} req_t;

	typedef struct packed {
		logic               hit;
		logic signed [31:0] read_value;
		logic               evicted;
		logic signed [31:0] evicted_key;
	} rsp_t;

	typedef logic [CAP_W-1:0] cap_t;

endpackage

// File: sv/lkvc_if.sv
// Valid/ready channel interfaces for the cache: request, response, configuration.
// Depends on lkvc_pkg.
interface lkvc_req_if;
	logic          valid;
	logic          ready;
	lkvc_pkg::req_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface lkvc_rsp_if;
	logic          valid;
	logic          ready;
	lkvc_pkg::rsp_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface lkvc_cfg_if;
	logic          valid;
	logic          ready;
	lkvc_pkg::cap_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// File: sv/lru_key_value_cache.sv
// Fully associative key-value cache with least-recently-used replacement.
// Depends on lkvc_pkg, lkvc_if, lkvc_ram and assert_macros.svh.
//
// A request beat (get or put) is taken into an input register; while it is held there its
// key is compared against all ENTRIES key cells at once. When the result register is free
// or its beat is being taken, the recency ranks, valid bits and occupancy are updated and
// the response is registered in the result register, which offers the response beat; a
// response not taken stalls the input register. One request is taken per cycle for as long
// as responses are taken; the rate is set by the compare and the rank update logic across
// all entries, both combinational. Values live in a RAM read on get hits; keys and ranks
// sit in per-entry registers. The capacity register (reset 16; 0 acts as 1, values above
// ENTRIES act as ENTRIES) is always ready and should be written while the cache is idle.
// No clearing pass is needed after reset.
`include "assert_macros.svh"

module lru_key_value_cache #(
	parameter int ENTRIES = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	lkvc_cfg_if.sink  cfg,
	lkvc_req_if.sink  req,
	lkvc_rsp_if.source rsp
);

	localparam int IdxW = $clog2(ENTRIES);
	localparam int CntW = $clog2(ENTRIES + 1);
	localparam int CmpW = (CntW > lkvc_pkg::CAP_W) ? CntW : lkvc_pkg::CAP_W;

	// state
	logic                cap_q_valid_unused;
	lkvc_pkg::cap_t      cap_q;
	logic [31:0]         keys_q  [ENTRIES];
	logic [IdxW-1:0]     rank_q  [ENTRIES];
	logic [ENTRIES-1:0]  valid_q;
	logic [CntW-1:0]     used_q;

	// input stage
	logic                valid_s1;
	lkvc_pkg::req_t      item_s1;

	// result stage
	logic                valid_s2;
	logic                hit_s2;
	logic                get_hit_s2;
	logic                evicted_s2;
	logic [31:0]         evkey_s2;

	// lookup
	logic [ENTRIES-1:0]  match;
	logic [ENTRIES-1:0]  victim;
	logic                found;
	logic [IdxW-1:0]     found_idx;
	logic [IdxW-1:0]     victim_idx;
	logic [IdxW-1:0]     free_idx;
	logic [IdxW-1:0]     ins_idx;
	logic [IdxW-1:0]     old_rank;
	logic [IdxW-1:0]     last_rank;
	logic [31:0]         evict_key;
	logic [CmpW-1:0]     eff_cap;
	logic                is_put;
	logic                do_insert;
	logic                do_evict;
	logic                adv;
	logic                req_acc;
	logic [31:0]         ram_rdata;

	assign cap_q_valid_unused = 1'b0;

	// handshakes
	assign adv     = valid_s1 && (!valid_s2 || rsp.ready);
	assign req.ready = !valid_s1 || adv;
	assign req_acc = req.valid && req.ready;
	assign cfg.ready = 1'b1;

	// capacity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= lkvc_pkg::CAP_RESET;
		end else if (cfg.valid && cfg.ready && !cap_q_valid_unused) begin
			cap_q <= cfg.data;
		end
	end

	// effective capacity, clamped to 1 .. ENTRIES
	always_comb begin
		eff_cap = CmpW'(cap_q);
		if (cap_q == '0) begin
			eff_cap = CmpW'(1);
		end else if (CmpW'(cap_q) > CmpW'(ENTRIES)) begin
			eff_cap = CmpW'(ENTRIES);
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_acc) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req_acc) begin
			item_s1 <= req.data;
		end
	end

	// least recent entry holds rank used-1
	assign last_rank = IdxW'(used_q - CntW'(1));

	// key compare and victim detect across all cells
	always_comb begin
		for (int i = 0; i < ENTRIES; i++) begin
			match[i]  = valid_q[i] && (keys_q[i] == item_s1.key);
			victim[i] = valid_q[i] && (rank_q[i] == last_rank);
		end
	end

	// encode the one-hot match and victim vectors
	always_comb begin
		found_idx  = '0;
		victim_idx = '0;
		old_rank   = '0;
		evict_key  = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			if (match[i]) begin
				found_idx = found_idx | IdxW'(i);
				old_rank  = old_rank | rank_q[i];
			end
			if (victim[i]) begin
				victim_idx = victim_idx | IdxW'(i);
				evict_key  = evict_key | keys_q[i];
			end
		end
	end

	// lowest free slot
	always_comb begin
		free_idx = '0;
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_idx = IdxW'(i);
			end
		end
	end

	assign found     = |match;
	assign is_put    = (item_s1.mode == lkvc_pkg::MODE_PUT);
	assign do_insert = is_put && !found;
	assign do_evict  = do_insert && (CmpW'(used_q) >= eff_cap);
	assign ins_idx   = do_evict ? victim_idx : free_idx;

	// recency, valid bits and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ENTRIES; i++) begin
				rank_q[i] <= '0;
			end
			valid_q <= '0;
			used_q  <= '0;
		end else if (adv) begin
			if (found) begin
				for (int i = 0; i < ENTRIES; i++) begin
					if (valid_q[i] && (rank_q[i] < old_rank)) begin
						rank_q[i] <= rank_q[i] + IdxW'(1);
					end
				end
				rank_q[found_idx] <= '0;
			end else if (do_insert) begin
				for (int i = 0; i < ENTRIES; i++) begin
					if (valid_q[i]) begin
						rank_q[i] <= rank_q[i] + IdxW'(1);
					end
				end
				rank_q[ins_idx]  <= '0;
				valid_q[ins_idx] <= 1'b1;
				if (!do_evict) begin
					used_q <= used_q + CntW'(1);
				end
			end
		end
	end

	// key cells
	always_ff @(posedge clk) begin
		if (adv && do_insert) begin
			keys_q[ins_idx] <= item_s1.key;
		end
	end

	// value store
	lkvc_ram #(
		.WIDTH (32),
		.DEPTH (ENTRIES)
	) u_values (
		.clk   (clk),
		.we    (adv && is_put),
		.waddr (found ? found_idx : ins_idx),
		.wdata (item_s1.write_value),
		.re    (adv && !is_put && found),
		.raddr (found_idx),
		.rdata (ram_rdata)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= 1'b1;
		end else if (rsp.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			hit_s2     <= found;
			get_hit_s2 <= found && !is_put;
			evicted_s2 <= do_evict;
			evkey_s2   <= do_evict ? evict_key : '0;
		end
	end

	assign rsp.valid = valid_s2;
	assign rsp.data  = '{
		hit:         hit_s2,
		read_value:  get_hit_s2 ? ram_rdata : lkvc_pkg::READ_MISS,
		evicted:     evicted_s2,
		evicted_key: evkey_s2
	};

	// checks
	`LKVC_ASSERT(a_match_unique, $onehot0(match), "key matches more than one entry")
	`LKVC_ASSERT(a_used_count, $countones(valid_q) == used_q, "occupancy disagrees with valid bits")
	`LKVC_ASSERT(a_victim_one, !(valid_s1 && do_evict) || $onehot(victim), "no unique victim")
	`LKVC_ASSERT_NEXT(a_touch_rank, adv && found, rank_q[$past(found_idx)] == '0, "touched entry not most recent")
	`LKVC_ASSERT_NEXT(a_fill_count, adv && do_insert && !do_evict, used_q == CntW'($past(used_q) + CntW'(1)), "insert did not grow occupancy")

endmodule

// File: sv/lkvc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lkvc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// read port, data held until the next enabled read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule
